### src/hmn_pkg.sv
// shared types and constants for the heightmap to normal map block
package hmn_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COORD_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COORD_W + 1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(256);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int SQRT_STEPS = 28;
  localparam int DIV_STEPS  = 18;
  localparam logic [17:0] Q_ONE = 18'd65536;

  typedef struct packed {
    logic [7:0]         h;
    logic [7:0]         l;
    logic [7:0]         rn;
    logic [7:0]         t;
    logic [7:0]         b;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [WIDTH_W-1:0] w;
    logic               done;
  } job_t;

endpackage

### src/hmn_ram.sv
// generic single port ram with registered read
module hmn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/hmn_fifo.sv
// short job queue between front and back
module hmn_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hmn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hmn_pkg::job_t pop_job,
  output logic          empty
);

  hmn_pkg::job_t entries [hmn_pkg::FIFO_DEPTH];
  logic [hmn_pkg::FIFO_AW-1:0] wr_ptr;
  logic [hmn_pkg::FIFO_AW-1:0] rd_ptr;
  logic [hmn_pkg::FIFO_AW:0]   count;

  assign full    = (count == (hmn_pkg::FIFO_AW+1)'(hmn_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (hmn_pkg::FIFO_AW+1)'(push && !full)
                     - (hmn_pkg::FIFO_AW+1)'(pop && !empty);
    end
  end

endmodule

### src/hmn_front.sv
// front: line stores, neighbour fetch and job issue
module hmn_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [hmn_pkg::WIDTH_W-1:0] width,
  input  logic [7:0]                  height,
  input  logic                        height_valid,
  output logic                        height_ready,
  output logic                        push,
  output hmn_pkg::job_t               push_job,
  input  logic                        full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD0  = 3'd1;
  localparam logic [2:0] F_RD1  = 3'd2;
  localparam logic [2:0] F_RD2  = 3'd3;
  localparam logic [2:0] F_RD3  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  localparam int CW = hmn_pkg::COORD_W;
  localparam int WW = hmn_pkg::WIDTH_W;

  logic [2:0]    state;
  logic [CW-1:0] col_counter;
  logic [CW-1:0] row_counter;
  logic [1:0]    rot;
  logic [1:0]    idx;
  logic [CW-1:0] c;
  logic [CW-1:0] r;
  logic [7:0]    h_in;
  logic [7:0]    p_l, p_c, p_r, o_c, c_l2, c_l1;

  logic [1:0]    prev_idx, old_idx;
  logic [CW-1:0] addr_cur, addr_prev, addr_old;
  logic          we_cur;
  logic [CW-1:0] bank_addr [3];
  logic          bank_we [3];
  logic [7:0]    bank_rd [3];
  logic [7:0]    cur_rd, prev_rd, old_rd;

  logic          last_row, need;
  logic [WW-1:0] c_ext, r_ext;

  assign prev_idx = (rot == 2'd0) ? 2'd2 : rot - 2'd1;
  assign old_idx  = (rot == 2'd2) ? 2'd0 : rot + 2'd1;
  assign cur_rd   = bank_rd[rot];
  assign prev_rd  = bank_rd[prev_idx];
  assign old_rd   = bank_rd[old_idx];

  always_comb begin
    addr_cur  = c;
    addr_prev = c;
    addr_old  = c;
    we_cur    = 1'b0;
    unique case (state)
      F_RD0: begin
        addr_prev = c - 1'b1;
        addr_cur  = c - 2'd2;
      end
      F_RD1: begin
        addr_cur = c - 1'b1;
      end
      F_RD2: begin
        addr_prev = c + 1'b1;
      end
      F_RD3: begin
        we_cur = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_bank
    always_comb begin
      if (rot == 2'(k)) begin
        bank_addr[k] = addr_cur;
        bank_we[k]   = we_cur;
      end else if (prev_idx == 2'(k)) begin
        bank_addr[k] = addr_prev;
        bank_we[k]   = 1'b0;
      end else begin
        bank_addr[k] = addr_old;
        bank_we[k]   = 1'b0;
      end
    end

    hmn_ram #(
      .WIDTH(8),
      .DEPTH(hmn_pkg::MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (bank_we[k]),
      .addr (bank_addr[k]),
      .wdata(h_in),
      .rdata(bank_rd[k])
    );
  end

  assign c_ext    = {1'b0, c};
  assign r_ext    = {1'b0, r};
  assign last_row = (r_ext == width - 1'b1);

  always_comb begin
    push_job = '0;
    push_job.w = width;
    unique case (idx)
      2'd0: begin
        need = (r != '0);
        push_job.h  = p_c;
        push_job.l  = p_l;
        push_job.rn = p_r;
        push_job.t  = h_in;
        push_job.b  = o_c;
        push_job.x  = c;
        push_job.y  = r - 1'b1;
      end
      2'd1: begin
        need = last_row && (c != '0);
        push_job.h  = c_l1;
        push_job.l  = c_l2;
        push_job.rn = h_in;
        push_job.b  = p_l;
        push_job.x  = c - 1'b1;
        push_job.y  = r;
      end
      default: begin
        need = last_row && (c_ext == width - 1'b1);
        push_job.h    = h_in;
        push_job.l    = c_l1;
        push_job.b    = p_c;
        push_job.x    = c;
        push_job.y    = r;
        push_job.done = 1'b1;
      end
    endcase
  end

  assign push         = (state == F_PUSH) && need && !full;
  assign height_ready = (state == F_IDLE) && !restart && !rst;

  always_ff @(posedge clk) begin
    if (state == F_IDLE && height_valid) begin
      h_in <= height;
    end
    if (state == F_RD1) begin
      p_l  <= prev_rd;
      o_c  <= old_rd;
      c_l2 <= cur_rd;
    end
    if (state == F_RD2) begin
      p_c  <= prev_rd;
      c_l1 <= cur_rd;
    end
    if (state == F_RD3) begin
      p_r <= prev_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      col_counter <= '0;
      row_counter <= '0;
      rot         <= '0;
      idx         <= '0;
      c           <= '0;
      r           <= '0;
    end else if (restart) begin
      col_counter <= '0;
      row_counter <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (height_valid) begin
            c     <= ({1'b0, col_counter} >= width) ? '0 : col_counter;
            r     <= ({1'b0, row_counter} >= width) ? '0 : row_counter;
            state <= F_RD0;
          end
        end
        F_RD0: state <= F_RD1;
        F_RD1: state <= F_RD2;
        F_RD2: state <= F_RD3;
        F_RD3: begin
          idx   <= 2'd0;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!need || !full) begin
            if (idx == 2'd2) begin
              state <= F_IDLE;
              if (c_ext + 1'b1 >= width) begin
                col_counter <= '0;
                rot         <= old_idx;
                row_counter <= (r_ext + 1'b1 >= width) ? '0 : r + 1'b1;
              end else begin
                col_counter <= c + 1'b1;
                row_counter <= r;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### src/hmn_back.sv
// back: normal vector, length, normalise and byte mapping
module hmn_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  hmn_pkg::job_t               pop_job,
  output logic                        pop,
  output logic [7:0]                  normal_x,
  output logic [7:0]                  normal_y,
  output logic [7:0]                  normal_z,
  output logic [hmn_pkg::COORD_W-1:0] pixel_col,
  output logic [hmn_pkg::COORD_W-1:0] pixel_row,
  output logic                        frame_done,
  output logic                        normal_valid,
  input  logic                        normal_ready
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_VEC  = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_MAP  = 3'd5;

  logic [2:0]          state;
  hmn_pkg::job_t       job;
  logic [4:0]          step;
  logic [10:0]         mag [3];
  logic                neg [3];
  logic [55:0]         rad;
  logic [31:0]         srem;
  logic [27:0]         root;
  logic [28:0]         drem [3];
  logic [17:0]         quo [3];

  logic                nl, nr, nt, nb;
  logic signed [9:0]   dl, dr, dt, db;
  logic signed [10:0]  sa, sb;
  logic signed [11:0]  vx, vy, vz;
  logic [21:0]         len2;
  logic [31:0]         s_try, s_trial;
  logic [28:0]         d_sh [3];
  logic [17:0]         q_cl [3];
  logic [17:0]         u [3];
  logic [25:0]         prod [3];
  logic [7:0]          byte_v [3];

  always_comb begin
    nl = (job.x != '0);
    nr = ({1'b0, job.x} + 1'b1) < job.w;
    nb = (job.y != '0);
    nt = ({1'b0, job.y} + 1'b1) < job.w;
    dl = $signed({2'b0, job.l}) - $signed({2'b0, job.h});
    dr = $signed({2'b0, job.h}) - $signed({2'b0, job.rn});
    dt = $signed({2'b0, job.h}) - $signed({2'b0, job.t});
    db = $signed({2'b0, job.b}) - $signed({2'b0, job.h});
    sa = (nl ? 11'(dl) : 11'sd0) + (nr ? 11'(dr) : 11'sd0);
    sb = (nt ? 11'(dt) : 11'sd0) + (nb ? 11'(db) : 11'sd0);
    vx = (nt && nb) ? (12'(sa) <<< 1) : 12'(sa);
    vz = (nl && nr) ? (12'(sb) <<< 1) : 12'(sb);
    vy = 12'((3'(nl) + 3'(nr)) * (3'(nt) + 3'(nb)));
  end

  assign len2 = 22'(mag[0] * mag[0]) + 22'(mag[1] * mag[1]) + 22'(mag[2] * mag[2]);

  assign s_try   = {srem[29:0], rad[55:54]};
  assign s_trial = {2'b0, root, 2'b01};

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign d_sh[k]   = {drem[k][27:0], 1'b0};
    assign q_cl[k]   = (quo[k] > hmn_pkg::Q_ONE) ? hmn_pkg::Q_ONE : quo[k];
    assign u[k]      = neg[k] ? (hmn_pkg::Q_ONE - q_cl[k]) : (hmn_pkg::Q_ONE + q_cl[k]);
    assign prod[k]   = {u[k], 8'b0} - 26'(u[k]);
    assign byte_v[k] = prod[k][24:17];
  end

  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
    unique case (state)
      B_VEC: begin
        neg[0] <= vx[11];
        neg[1] <= vy[11];
        neg[2] <= vz[11];
        mag[0] <= vx[11] ? 11'(-vx) : 11'(vx);
        mag[1] <= vy[11] ? 11'(-vy) : 11'(vy);
        mag[2] <= vz[11] ? 11'(-vz) : 11'(vz);
      end
      B_SQ: begin
        rad  <= {2'b0, len2, 32'b0};
        srem <= '0;
        root <= '0;
      end
      B_SQRT: begin
        rad <= {rad[53:0], 2'b0};
        if (s_try >= s_trial) begin
          srem <= s_try - s_trial;
          root <= {root[26:0], 1'b1};
        end else begin
          srem <= s_try;
          root <= {root[26:0], 1'b0};
        end
        for (int k = 0; k < 3; k++) begin
          drem[k] <= {4'b0, mag[k], 14'b0};
          quo[k]  <= '0;
        end
      end
      B_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (d_sh[k] >= {1'b0, root}) begin
            drem[k] <= d_sh[k] - {1'b0, root};
            quo[k]  <= {quo[k][16:0], 1'b1};
          end else begin
            drem[k] <= d_sh[k];
            quo[k]  <= {quo[k][16:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
    if (state == B_MAP && (!normal_valid || normal_ready)) begin
      normal_x   <= byte_v[0];
      normal_y   <= byte_v[1];
      normal_z   <= byte_v[2];
      pixel_col  <= job.x;
      pixel_row  <= job.y;
      frame_done <= job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      step         <= '0;
      normal_valid <= 1'b0;
    end else begin
      if (state == B_MAP && (!normal_valid || normal_ready)) begin
        normal_valid <= 1'b1;
      end else if (normal_valid && normal_ready) begin
        normal_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= B_VEC;
          end
        end
        B_VEC: state <= B_SQ;
        B_SQ: begin
          step  <= '0;
          state <= B_SQRT;
        end
        B_SQRT: begin
          if (step == 5'(hmn_pkg::SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= B_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end
        B_DIV: begin
          if (step == 5'(hmn_pkg::DIV_STEPS - 1)) begin
            state <= B_MAP;
          end else begin
            step <= step + 1'b1;
          end
        end
        B_MAP: begin
          if (!normal_valid || normal_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### src/heightmap_to_normal_map.sv
// top level: register port, front, job queue and back
// the front accepts a new sample only when idle; the back handles one normal word at a time
// through the 28-step square root and the 18-step divider lanes
// reset: counters and handshakes clear, width returns to 256; line stores are not cleared
module heightmap_to_normal_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic [7:0]                  height,
  input  logic                        height_valid,
  output logic                        height_ready,
  output logic [7:0]                  normal_x,
  output logic [7:0]                  normal_y,
  output logic [7:0]                  normal_z,
  output logic [hmn_pkg::COORD_W-1:0] pixel_col,
  output logic [hmn_pkg::COORD_W-1:0] pixel_row,
  output logic                        frame_done,
  output logic                        normal_valid,
  input  logic                        normal_ready
);

  localparam int WW = hmn_pkg::WIDTH_W;

  logic [WW-1:0] image_width;
  logic [WW-1:0] width_eff;
  logic          cfg_write;
  logic          push, full, pop, empty;
  hmn_pkg::job_t push_job, pop_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {{(32-WW){1'b0}}, image_width} : '0;

  assign width_eff = (image_width < WW'(2)) ? WW'(2)
                   : (image_width > WW'(hmn_pkg::MAX_WIDTH)) ? WW'(hmn_pkg::MAX_WIDTH)
                   : image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= hmn_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      image_width <= pwdata[WW-1:0];
    end
  end

  hmn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .width       (width_eff),
    .height      (height),
    .height_valid(height_valid),
    .height_ready(height_ready),
    .push        (push),
    .push_job    (push_job),
    .full        (full)
  );

  hmn_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (empty)
  );

  hmn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .frame_done  (frame_done),
    .normal_valid(normal_valid),
    .normal_ready(normal_ready)
  );

endmodule

### tb/heightmap_to_normal_map_test.sv
// self-checking testbench for the heightmap to normal map block
`timescale 1ns / 100ps

module heightmap_to_normal_map_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 200;
  localparam int DIR_ROWS    = 22;

  typedef struct packed {
    logic [7:0]                  nx;
    logic [7:0]                  ny;
    logic [7:0]                  nz;
    logic [hmn_pkg::COORD_W-1:0] col;
    logic [hmn_pkg::COORD_W-1:0] row;
    logic                        done;
  } normal_word_t;

  typedef struct packed {
    logic        cfg;
    logic [10:0] wval;
    logic [7:0]  h;
    logic        typed;
    logic [7:0]  tx;
    logic [7:0]  ty;
    logic [7:0]  tz;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic [7:0] height = '0;
  logic height_valid = 1'b0;
  logic height_ready;
  logic [7:0] normal_x, normal_y, normal_z;
  logic [hmn_pkg::COORD_W-1:0] pixel_col, pixel_row;
  logic frame_done;
  logic normal_valid;
  logic normal_ready = 1'b0;

  heightmap_to_normal_map i_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [7:0] line_older [hmn_pkg::MAX_WIDTH];
  logic [7:0] line_prev  [hmn_pkg::MAX_WIDTH];
  logic [7:0] line_cur   [hmn_pkg::MAX_WIDTH];
  int unsigned width_reg = 256;
  int unsigned col_cnt = 0, row_cnt = 0;

  normal_word_t expected_normals[$];
  logic typed_on = 1'b0;
  logic [7:0] typed_x, typed_y, typed_z;

  int gap_pct = 0, stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] unit_to_byte(int v, longint unsigned s);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag << 32) / s;
    if (q > 65536) q = 65536;
    if (v < 0) q = -q;
    return 8'(((q + 65536) * 255) >>> 17);
  endfunction

  task automatic expect_normal(int unsigned x, int unsigned y, int unsigned w,
                               int h, int l, int r, int t, int b, logic done);
    int nl, nr, nb, nt, vx, vy, vz;
    longint unsigned len2, s;
    normal_word_t e;
    nl = x > 0;
    nr = x + 1 < w;
    nb = y > 0;
    nt = y + 1 < w;
    vx = (nt + nb) * (nl * (l - h) + nr * (h - r));
    vy = (nl + nr) * (nt + nb);
    vz = (nl + nr) * (nt * (h - t) + nb * (b - h));
    len2 = longint'(vx) * vx + longint'(vy) * vy + longint'(vz) * vz;
    s = int_sqrt(len2 << 32);
    if (s == 0) s = 1;
    e.nx = unit_to_byte(vx, s);
    e.ny = unit_to_byte(vy, s);
    e.nz = unit_to_byte(vz, s);
    if (typed_on) begin
      e.nx = typed_x;
      e.ny = typed_y;
      e.nz = typed_z;
    end
    e.col = hmn_pkg::COORD_W'(x);
    e.row = hmn_pkg::COORD_W'(y);
    e.done = done;
    expected_normals.insert(expected_normals.size(), e);
  endtask

  task automatic predict_sample(logic [7:0] hv);
    int unsigned w, c, r;
    int l, rr, b;
    w = width_reg < 2 ? 2 :
        (width_reg > hmn_pkg::MAX_WIDTH ? hmn_pkg::MAX_WIDTH : width_reg);
    c = col_cnt >= w ? 0 : col_cnt;
    r = row_cnt >= w ? 0 : row_cnt;
    line_cur[c] = hv;
    if (r >= 1) begin
      l = c > 0 ? line_prev[c-1] : 0;
      rr = c + 1 < w ? line_prev[c+1] : 0;
      b = r >= 2 ? line_older[c] : 0;
      expect_normal(c, r - 1, w, line_prev[c], l, rr, hv, b, 1'b0);
    end
    if (r == w - 1) begin
      if (c >= 1) begin
        l = c >= 2 ? line_cur[c-2] : 0;
        expect_normal(c - 1, r, w, line_cur[c-1], l, hv, 0, line_prev[c-1], 1'b0);
      end
      if (c == w - 1)
        expect_normal(c, r, w, hv, line_cur[c-1], 0, 0, line_prev[c], 1'b1);
    end
    c++;
    if (c >= w) begin
      c = 0;
      for (int i = 0; i < w; i++) begin
        line_older[i] = line_prev[i];
        line_prev[i] = line_cur[i];
      end
      r++;
      if (r >= w) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic send_sample(logic [7:0] hv);
    while ($urandom_range(99) < gap_pct) begin
      height_valid <= 1'b0;
      @(posedge clk);
    end
    height <= hv;
    height_valid <= 1'b1;
    do @(posedge clk); while (!height_ready);
    predict_sample(hv);
  endtask

  task automatic drain;
    height_valid <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(logic [10:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    width_reg = v;
    col_cnt = 0;
    row_cnt = 0;
  endtask

  task automatic send_frame(int unsigned count, logic hold);
    for (int i = 0; i < count; i++) begin
      if (hold && i == count / 2) begin
        height_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge clk);
      end
      send_sample(8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    normal_word_t e, got;
    if (!rst && normal_valid && normal_ready) begin
      got = '{normal_x, normal_y, normal_z, pixel_col, pixel_row, frame_done};
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: %p", got);
      end else begin
        e = expected_normals.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", e, got);
        end
      end
    end
    normal_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("heightmap_to_normal_map_test: FAIL");
      $finish;
    end
  end

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, 11'd0,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd0,   1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd0,   1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd0,   1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd0,   1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd255, 1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd255, 1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd255, 1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b0, 11'd0,    8'd255, 1'b1, 8'd127, 8'd255, 8'd127},
    '{1'b1, 11'd1,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b1, 11'd3,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd128, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd1,   1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd254, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd127, 1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b0, 11'd0,    8'd255, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  initial begin
    int unsigned w, sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_width(dir_rows[i].wval);
      end else begin
        typed_on = dir_rows[i].typed;
        typed_x = dir_rows[i].tx;
        typed_y = dir_rows[i].ty;
        typed_z = dir_rows[i].tz;
        send_sample(dir_rows[i].h);
      end
    end
    typed_on = 1'b0;
    // finish the 3x3 frame
    repeat (2) send_sample(8'd0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 80; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      sent = 0;
      while (sent < 10) begin
        w = $urandom_range(5, 2);
        write_width(11'(w));
        if ($urandom_range(4) == 0) begin
          // broken frame, cut short by the next width write
          send_frame($urandom_range(w * w - 1, 1), 1'b0);
        end else begin
          send_frame(w * w, p == 0 && sent == 0);
          sent += w * w;
        end
      end
    end

    // over-range value acts as the widest image; the first row gives no words
    gap_pct = 0;
    stall_pct = 0;
    write_width(11'h7FF);
    send_frame(6, 1'b0);
    write_width(11'd2);
    send_frame(4, 1'b0);

    drain();
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("heightmap_to_normal_map_test: PASS");
    end else begin
      $display("heightmap_to_normal_map_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/hmn_pkg.sv
src/hmn_ram.sv
src/hmn_fifo.sv
src/hmn_front.sv
src/hmn_back.sv
src/heightmap_to_normal_map.sv
tb/heightmap_to_normal_map_test.sv
